// ----- rtl/fl3_pkg.sv -----
`default_nettype none

package fl3_pkg;

    // Line store sizing
    localparam int MAX_WIDTH  = 1024;
    localparam int LINE_DEPTH = MAX_WIDTH + 2;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int ROW_W      = 17;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int IW_W       = 11;
    localparam int IH_W       = 16;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Register reset values
    localparam int INNER_WIDTH_RST  = 1024;
    localparam int INNER_HEIGHT_RST = 1024;

    // Arithmetic
    localparam int PIX_MAX    = 255;
    localparam int SUM_W      = 12;         // nine 8-bit pixels
    localparam int SHARP_W    = 12;         // -1020 .. 1275, signed
    localparam int DIV9_MUL   = 7282;       // ceil(2^16 / 9), exact for sums up to 2295
    localparam int DIV9_SHIFT = 16;
    localparam int DIV9_MW    = 13;
    localparam int MUL_W      = SUM_W + DIV9_MW;

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;

    // One window column: three vertically adjacent pixels
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } column_t;

endpackage

`default_nettype wire

// ----- rtl/fl3_ram.sv -----
`default_nettype none

module fl3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1026
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/fl3_col_cell.sv -----
`default_nettype none

module fl3_col_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  fl3_pkg::column_t col_in,
    output fl3_pkg::column_t col_out
);

    fl3_pkg::column_t col_reg;

    // One window column; passes its content to the next cell on each shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

// ----- rtl/image_3x3_blur_sharpen_filter_core.sv -----
// 3x3 streaming image filter. Pixels of a frame padded by one pixel on each
// side enter in raster order, (inner_height+2) rows of (inner_width+2)
// pixels, one transfer per clock while in_stall is low. Each interior
// position yields one result: the floor of the 3x3 mean (filter_mode 0)
// or five times the center minus its four cross neighbors clamped to 0..255
// (filter_mode 1); frame_end marks the last result of a frame. The block
// sustains one pixel per clock while out_stall is low: each line store is
// one RAM read and written once per cycle, and the window is a chain of
// two column cells. A result goes through the line store read and window sum
// or sharpen into stage 2, then blur's divide by 9 into the output register.
// inner_width 0 acts as 1 and values above 1024 as 1024; inner_height 0
// acts as 1. Writing inner_width or inner_height restarts the frame. Write
// the registers only while the block is idle. pready is always high.
`default_nettype none

module image_3x3_blur_sharpen_filter_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fl3_pkg::ADDR_W-1:0]   paddr,
    input  logic [fl3_pkg::DATA_W-1:0]   pwdata,
    output logic [fl3_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // Pixel input
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [fl3_pkg::PIX_W-1:0]    pixel_in,
    // Result output
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [fl3_pkg::PIX_W-1:0]    pixel_out,
    output logic                         frame_end
);

    localparam int COL_W = fl3_pkg::COL_W;
    localparam int ROW_W = fl3_pkg::ROW_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                      mode_reg;
    logic [fl3_pkg::IW_W-1:0]  iw_reg;
    logic [fl3_pkg::IH_W-1:0]  ih_reg;
    logic                      cfg_wr;
    fl3_pkg::reg_idx_t         cfg_idx;
    logic                      size_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = fl3_pkg::reg_idx_t'(paddr[3:2]);
    assign size_wr = cfg_wr && (cfg_idx == fl3_pkg::REG_WIDTH ||
                                cfg_idx == fl3_pkg::REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            iw_reg   <= fl3_pkg::IW_W'(fl3_pkg::INNER_WIDTH_RST);
            ih_reg   <= fl3_pkg::IH_W'(fl3_pkg::INNER_HEIGHT_RST);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                fl3_pkg::REG_MODE:   mode_reg <= pwdata[0];
                fl3_pkg::REG_WIDTH:  iw_reg   <= pwdata[fl3_pkg::IW_W-1:0];
                fl3_pkg::REG_HEIGHT: ih_reg   <= pwdata[fl3_pkg::IH_W-1:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb
    begin
        unique case (cfg_idx)
            fl3_pkg::REG_MODE:   prdata = fl3_pkg::DATA_W'(mode_reg);
            fl3_pkg::REG_WIDTH:  prdata = fl3_pkg::DATA_W'(iw_reg);
            fl3_pkg::REG_HEIGHT: prdata = fl3_pkg::DATA_W'(ih_reg);
            default:             prdata = '0;
        endcase
    end

    // Effective frame size
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    always_comb
    begin
        priority if (iw_reg == '0)
            w_eff = COL_W'(1);
        else if (32'(iw_reg) > 32'(fl3_pkg::MAX_WIDTH))
            w_eff = COL_W'(fl3_pkg::MAX_WIDTH);
        else
            w_eff = COL_W'(iw_reg);
    end

    assign h_eff    = (ih_reg == '0) ? ROW_W'(1) : ROW_W'(ih_reg);
    assign col_last = w_eff + COL_W'(1);
    assign row_last = h_eff + ROW_W'(1);

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic out_free, s2_free, s1_free, s1_move, in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign in_stall  = !s1_free;
    assign in_accept = in_valid && s1_free;

    // ------------------------------------------------------------------
    // Frame position counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic             col_at_end, row_at_end;

    assign col_at_end = (col_cnt_reg == col_last);
    assign row_at_end = (row_cnt_reg == row_last);

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        priority if (size_wr)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (in_accept)
        begin
            if (col_at_end)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_at_end ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read in flight
    // ------------------------------------------------------------------
    fl3_pkg::pix_t    s1_pix_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic             s1_prod_reg, s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg  <= pixel_in;
            s1_addr_reg <= col_cnt_reg;
            s1_prod_reg <= (row_cnt_reg >= ROW_W'(2)) && (col_cnt_reg >= COL_W'(2));
            s1_last_reg <= col_at_end && row_at_end;
        end
    end

    // Line stores: upper holds row r-2, middle row r-1
    fl3_pkg::pix_t up_rd, mid_rd;

    fl3_ram #(
        .WIDTH (fl3_pkg::PIX_W),
        .DEPTH (fl3_pkg::LINE_DEPTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_addr_reg),
        .wdata (mid_rd),
        .re    (in_accept),
        .raddr (col_cnt_reg),
        .rdata (up_rd)
    );

    fl3_ram #(
        .WIDTH (fl3_pkg::PIX_W),
        .DEPTH (fl3_pkg::LINE_DEPTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_addr_reg),
        .wdata (s1_pix_reg),
        .re    (in_accept),
        .raddr (col_cnt_reg),
        .rdata (mid_rd)
    );

    // Window: chain of two column cells (near = column c-1, far = c-2)
    fl3_pkg::column_t cur_col, near_col, far_col;

    assign cur_col = '{top: up_rd, mid: mid_rd, bot: s1_pix_reg};

    fl3_col_cell u_cell_near (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_move),
        .col_in   (cur_col),
        .col_out  (near_col)
    );

    fl3_col_cell u_cell_far (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_move),
        .col_in   (near_col),
        .col_out  (far_col)
    );

    // Window sum for blur
    logic [fl3_pkg::SUM_W-1:0] win_sum;

    assign win_sum = fl3_pkg::SUM_W'(far_col.top)  + fl3_pkg::SUM_W'(far_col.mid)
                   + fl3_pkg::SUM_W'(far_col.bot)  + fl3_pkg::SUM_W'(near_col.top)
                   + fl3_pkg::SUM_W'(near_col.mid) + fl3_pkg::SUM_W'(near_col.bot)
                   + fl3_pkg::SUM_W'(up_rd)        + fl3_pkg::SUM_W'(mid_rd)
                   + fl3_pkg::SUM_W'(s1_pix_reg);

    // Cross sharpen with clamp
    logic [fl3_pkg::SHARP_W-1:0]        five_c, edge_sum;
    logic signed [fl3_pkg::SHARP_W-1:0] sharp_val;
    fl3_pkg::pix_t                      sharp_pix;

    assign five_c    = (fl3_pkg::SHARP_W'(near_col.mid) << 2)
                     + fl3_pkg::SHARP_W'(near_col.mid);
    assign edge_sum  = fl3_pkg::SHARP_W'(near_col.top) + fl3_pkg::SHARP_W'(near_col.bot)
                     + fl3_pkg::SHARP_W'(far_col.mid)  + fl3_pkg::SHARP_W'(mid_rd);
    assign sharp_val = signed'(five_c - edge_sum);

    always_comb
    begin
        priority if (sharp_val[fl3_pkg::SHARP_W-1])
            sharp_pix = '0;
        else if (unsigned'(sharp_val) > fl3_pkg::SHARP_W'(fl3_pkg::PIX_MAX))
            sharp_pix = fl3_pkg::PIX_W'(fl3_pkg::PIX_MAX);
        else
            sharp_pix = sharp_val[fl3_pkg::PIX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: kernel results registered
    // ------------------------------------------------------------------
    logic                      s2_mode_reg, s2_last_reg;
    logic [fl3_pkg::SUM_W-1:0] s2_sum_reg;
    fl3_pkg::pix_t             s2_sharp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_move && s1_prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s2_free)
        begin
            s2_mode_reg  <= mode_reg;
            s2_last_reg  <= s1_last_reg;
            s2_sum_reg   <= win_sum;
            s2_sharp_reg <= sharp_pix;
        end
    end

    // Divide by 9 through reciprocal multiply
    logic [fl3_pkg::MUL_W-1:0] div_prod;
    fl3_pkg::pix_t             blur_pix;

    assign div_prod = fl3_pkg::MUL_W'(s2_sum_reg) * fl3_pkg::MUL_W'(fl3_pkg::DIV9_MUL);
    assign blur_pix = div_prod[fl3_pkg::DIV9_SHIFT +: fl3_pkg::PIX_W];

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    fl3_pkg::pix_t pix_out_reg;
    logic          frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_free)
        begin
            pix_out_reg   <= s2_mode_reg ? s2_sharp_reg : blur_pix;
            frame_end_reg <= s2_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pix_out_reg;
    assign frame_end = frame_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_cnt_reg <= col_last)
        else $error("column counter beyond row end");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_cnt_reg <= row_last)
        else $error("row counter beyond frame end");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && col_at_end && row_at_end |=> col_cnt_reg == '0 && row_cnt_reg == '0)
        else $error("frame position did not wrap after last pixel");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty pipeline");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_free |=> s2_valid_reg && $stable(s2_sum_reg))
        else $error("kernel stage lost data while blocked");

endmodule

`default_nettype wire
